@@ src/fds_pkg.sv @@
// fds_pkg: shared types and widths for the face depth order sorter
// no dependencies; used by the channel interfaces, fds_pick and the top level

package fds_pkg;

   localparam int IndexW = 6;
   localparam int DepthW = 32;

   typedef logic signed [DepthW-1:0] depth_type;
   typedef logic [IndexW-1:0]        index_type;

   // one read beat of the depth memory, handed to the pick unit
   typedef struct packed {
      logic      start;
      logic      vld;
      logic      drawn;
      index_type idx;
      depth_type far;
   } scan_type;

   // running result of one selection pass
   typedef struct packed {
      logic      found;
      index_type pick;
      logic      fb_found;
      index_type fb_idx;
   } pick_type;

endpackage

@@ src/fds_req_if.sv @@
// fds_req_if: face load channel (valid/ready with depth payload)
// depends on fds_pkg

interface fds_req_if
   import fds_pkg::*;
();
   logic      valid;
   logic      ready;
   depth_type near_depth;
   depth_type far_depth;
   logic      final_face;

   modport source (output valid, near_depth, far_depth, final_face, input ready);
   modport sink   (input valid, near_depth, far_depth, final_face, output ready);
endinterface

@@ src/fds_rsp_if.sv @@
// fds_rsp_if: drawing order result channel (valid/ready with index payload)
// depends on fds_pkg

interface fds_rsp_if
   import fds_pkg::*;
();
   logic      valid;
   logic      ready;
   index_type face_index;
   logic      none_eligible;
   logic      last_of_order;

   modport source (output valid, face_index, none_eligible, last_of_order, input ready);
   modport sink   (input valid, face_index, none_eligible, last_of_order, output ready);
endinterface

@@ src/fds_pick.sv @@
// fds_pick: compare stage of one selection pass over the depth memory
// depends on fds_pkg; fed one registered memory beat per cycle by the top level

module fds_pick
   import fds_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  scan_type  scan,
   input  depth_type gmin,
   output pick_type  pick
);

   logic      found_ff;
   logic      fb_found_ff;
   index_type pick_ff;
   index_type fb_idx_ff;
   depth_type best_ff;

   // control flags of the running pass
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff    <= 1'b0;
         fb_found_ff <= 1'b0;
      end else if (scan.start) begin
         found_ff    <= 1'b0;
         fb_found_ff <= 1'b0;
      end else if (scan.vld && !scan.drawn) begin
         if (scan.far >= best_ff) begin
            found_ff <= 1'b1;
         end
         fb_found_ff <= 1'b1;
      end
   end

   // best depth so far, ties go to the later index; first undrawn as fallback
   always_ff @(posedge clock) begin
      if (scan.start) begin
         best_ff <= gmin;
      end else if (scan.vld && !scan.drawn) begin
         if (scan.far >= best_ff) begin
            best_ff <= scan.far;
            pick_ff <= scan.idx;
         end
         if (!fb_found_ff) begin
            fb_idx_ff <= scan.idx;
         end
      end
   end

   assign pick.found    = found_ff;
   assign pick.pick     = pick_ff;
   assign pick.fb_found = fb_found_ff;
   assign pick.fb_idx   = fb_idx_ff;

endmodule

@@ src/face_depth_order_sorter.sv @@
// face_depth_order_sorter: painter's order sorter; faces load while idle and,
// after the final face, every index costs one pass (a read of each loaded
// face from the depth memory, a compare drain, then the issue).
// A load is taken again once the last index sits in the output register.
// Reset clears the control state, face count and drawn marks; the depth
// memory and near minimum are not cleared and only ever read once written.

module face_depth_order_sorter
   import fds_pkg::*;
#(
   parameter int MAX_FACES = 64
) (
   input  logic         clock,
   input  logic         reset,
   fds_req_if.sink      req_chan,
   fds_rsp_if.source    rsp_chan
);

   localparam int AddrW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
   localparam int CntW  = $clog2(MAX_FACES + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_DONE} state_type;

   state_type            state_ff, state_in;
   logic [CntW-1:0]      count_ff, count_in;
   logic [CntW-1:0]      addr_ff, addr_in;
   logic [CntW-1:0]      emit_ff, emit_in;
   depth_type            gmin_ff, gmin_in;
   logic [MAX_FACES-1:0] marks_ff, marks_in;
   logic                 rd_vld_ff, rd_vld_in;
   index_type            rd_idx_ff, rd_idx_in;
   logic                 mark_rd_ff, mark_rd_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   index_type            rsp_idx_ff, rsp_idx_in;
   logic                 rsp_none_ff, rsp_none_in;
   logic                 rsp_last_ff, rsp_last_in;

   depth_type            mem [MAX_FACES];
   depth_type            mem_rd_ff;

   logic                 load_fire;
   logic                 load_we;
   logic                 rd_en;
   logic                 slot_free;
   logic                 start;
   logic                 is_last;
   index_type            sel_idx;
   scan_type             scan;
   pick_type             pick;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign load_fire      = req_chan.valid && req_chan.ready;
   assign load_we        = load_fire && (count_ff < CntW'(MAX_FACES));
   assign rd_en          = (state_ff == ST_SCAN);
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign is_last        = (emit_ff == (count_ff - CntW'(1)));
   assign sel_idx        = pick.found ? pick.pick : pick.fb_idx;

   // depth memory: one write port for loads, one registered read port for scans
   always_ff @(posedge clock) begin
      if (load_we) begin
         mem[count_ff[AddrW-1:0]] <= req_chan.far_depth;
      end
      if (rd_en) begin
         mem_rd_ff <= mem[addr_ff[AddrW-1:0]];
      end
   end

   // beat into the pick unit
   assign scan.start = start;
   assign scan.vld   = rd_vld_ff;
   assign scan.drawn = mark_rd_ff;
   assign scan.idx   = rd_idx_ff;
   assign scan.far   = mem_rd_ff;

   // threshold taken with the start beat, so it covers the face loaded alongside it
   fds_pick u_pick (
      .clock (clock),
      .reset (reset),
      .scan  (scan),
      .gmin  (gmin_in),
      .pick  (pick)
   );

   // next state and registered outputs
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      emit_in      = emit_ff;
      gmin_in      = gmin_ff;
      marks_in     = marks_ff;
      rd_vld_in    = rd_en;
      rd_idx_in    = IndexW'(addr_ff);
      mark_rd_in   = marks_ff[addr_ff[AddrW-1:0]];
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_none_in  = rsp_none_ff;
      rsp_last_in  = rsp_last_ff;
      start        = 1'b0;

      // face load
      if (load_we) begin
         count_in = count_ff + CntW'(1);
         if ((count_ff == '0) || (req_chan.near_depth < gmin_ff)) begin
            gmin_in = req_chan.near_depth;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (load_fire && req_chan.final_face) begin
               state_in = ST_SCAN;
               addr_in  = '0;
               emit_in  = '0;
               start    = 1'b1;
            end
         end
         ST_SCAN: begin
            addr_in = addr_ff + CntW'(1);
            if (addr_ff == (count_ff - CntW'(1))) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = sel_idx;
               rsp_none_in  = !pick.found;
               rsp_last_in  = is_last;
               if (is_last) begin
                  state_in = ST_IDLE;
                  count_in = '0;
                  marks_in = '0;
               end else begin
                  marks_in[sel_idx[AddrW-1:0]] = 1'b1;
                  state_in = ST_SCAN;
                  addr_in  = '0;
                  emit_in  = emit_ff + CntW'(1);
                  start    = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state, counters and output beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         addr_ff      <= '0;
         emit_ff      <= '0;
         marks_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         addr_ff      <= addr_in;
         emit_ff      <= emit_in;
         marks_ff     <= marks_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      gmin_ff     <= gmin_in;
      rd_idx_ff   <= rd_idx_in;
      mark_rd_ff  <= mark_rd_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_none_ff <= rsp_none_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.face_index    = rsp_idx_ff;
   assign rsp_chan.none_eligible = rsp_none_ff;
   assign rsp_chan.last_of_order = rsp_last_ff;

`ifndef SYNTHESIS
   // a finished pass always has some undrawn face to give
   a_pass_has_pick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (pick.found || pick.fb_found))
      else $error("selection pass ended with no undrawn face");

   // no face is issued twice in one order
   a_pick_undrawn: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && slot_free) |-> !marks_ff[sel_idx[AddrW-1:0]])
      else $error("face issued twice");

   // the face count never passes capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MAX_FACES))
      else $error("face count beyond capacity");

   // while sorting, the issue count stays below the loaded count
   a_emit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (emit_ff < count_ff))
      else $error("issue count out of range");
`endif

endmodule
